FILE: rtl/core/rslr_pkg.sv
package rslr_pkg;

  // Command codes carried in the request tuser bit
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Sequencer states of the line setup and pixel stepping
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ORDER,
    ST_DIVIDE,
    ST_FIRST
  } rslr_state_e;

  // Status of the divider toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rslr_div_status_t;

endpackage

FILE: rtl/core/rslr_div.sv
module rslr_div
  import rslr_pkg::*;
#(
  parameter int W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     dividend_i,
  input  logic [W-1:0]     divisor_i,
  output rslr_div_status_t status_o,
  output logic [W-1:0]     quotient_o,
  output logic [W-1:0]     remainder_o
);

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] ITER = CW'(W);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = !diff[W];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = ITER;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

FILE: rtl/core/run_slice_line_rasterizer.sv
// Run-slice line rasterizer.
// Requests enter on the s_axis group: tuser selects start (0) or next (1),
// tdata carries both endpoints, used by start only. Pixels leave on the
// m_axis group with tlast set on the final pixel of the line.
// A start request passes the setup states ST_DIFF and ST_ORDER, forming
// the deltas, then the restoring divider splits the pixel count into
// runs, one quotient bit per cycle, and the first pixel is loaded into
// the output register. The request side is not ready during that setup.
// Each next request is taken and its pixel is in the output register on
// the following edge, so a stream of next requests gives one pixel per
// cycle while the receiver keeps up. A next request while no line is
// active is taken and gives no pixel; a start while a line runs drops
// that line. While a pixel waits in the output register and the receiver
// stalls, the block stops taking requests; it resumes in the cycle the
// pixel is taken. Reset clears the sequencer, the output valid flag and
// the line state, not the payload; the block comes up idle, no line active.
module run_slice_line_rasterizer
  import rslr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: x_a, y_a, x_b, y_b (low to high), zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata_i,
  // tuser: command
  input  logic                                    s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // tdata: pixel_x, pixel_y (low to high), zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);

  localparam int C     = COORD_BITS;
  localparam int N     = COORD_BITS + 1;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  rslr_state_e state_q, state_d;

  logic [C-1:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [N-1:0] ddx_q, ddx_d, ddy_q, ddy_d;
  logic         swap_q, swap_d;
  logic [C-1:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic         down_q, down_d, horiz_q, horiz_d;
  logic [N-1:0] total_q, total_d, run_count_q, run_count_d;
  logic [N-1:0] base_len_q, base_len_d, leftover_q, leftover_d;
  logic [N-1:0] acc_q, acc_d, run_idx_q, run_idx_d;
  logic [N-1:0] cur_len_q, cur_len_d, pos_q, pos_d, major_q, major_d;
  logic         busy_q, busy_d;
  logic         out_valid_q, out_valid_d;
  logic [C-1:0] px_q, px_d, py_q, py_d;
  logic         last_q, last_d;

  logic         in_acc;
  logic         out_free;
  logic         step_en;
  logic         div_start;
  logic [N-1:0] div_dividend, div_divisor, div_quo, div_rem;
  rslr_div_status_t div_status;

  // Setup arithmetic
  logic [N-1:0] dx_abs, dy_abs, dmin, dmax;

  // Stepper arithmetic
  logic [N-1:0] offx, offy;
  logic [C-1:0] step_px, step_py;
  logic [N:0]   major_inc, pos_inc, acc_sum, acc_new_w, extra_sum;
  logic [N-1:0] acc_new, cur_len_new;
  logic         step_last, run_end, next_extra;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Absolute deltas and major/minor split
  assign dx_abs = ddx_q[N-1] ? (N'(0) - ddx_q) : ddx_q;
  assign dy_abs = ddy_q[N-1] ? (N'(0) - ddy_q) : ddy_q;
  assign dmin   = (dx_abs < dy_abs) ? dx_abs : dy_abs;
  assign dmax   = (dx_abs < dy_abs) ? dy_abs : dx_abs;

  // Pixel position from the base point and the two offsets
  assign offx    = horiz_q ? major_q : run_idx_q;
  assign offy    = horiz_q ? run_idx_q : major_q;
  assign step_px = base_x_q + offx[C-1:0];
  assign step_py = down_q ? (base_y_q - offy[C-1:0]) : (base_y_q + offy[C-1:0]);

  // Advance counters; wrap the accumulator at the end of a run
  assign major_inc   = {1'b0, major_q} + 1'b1;
  assign step_last   = major_inc >= {1'b0, total_q};
  assign pos_inc     = {1'b0, pos_q} + 1'b1;
  assign run_end     = pos_inc >= {1'b0, cur_len_q};
  assign acc_sum     = {1'b0, acc_q} + {1'b0, leftover_q};
  assign acc_new_w   = (acc_sum >= {1'b0, run_count_q}) ?
                       (acc_sum - {1'b0, run_count_q}) : acc_sum;
  assign acc_new     = acc_new_w[N-1:0];
  assign extra_sum   = {1'b0, acc_new} + {1'b0, leftover_q};
  assign next_extra  = extra_sum >= {1'b0, run_count_q};
  assign cur_len_new = base_len_q + N'(next_extra);

  // Divider: pixel count over run count, taken as they are formed
  assign div_dividend = total_d;
  assign div_divisor  = run_count_d;

  rslr_div #(
    .W (N)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .status_o    (div_status),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer: next state and register updates
  always_comb begin
    state_d     = state_q;
    xa_d        = xa_q;
    ya_d        = ya_q;
    xb_d        = xb_q;
    yb_d        = yb_q;
    ddx_d       = ddx_q;
    ddy_d       = ddy_q;
    swap_d      = swap_q;
    base_x_d    = base_x_q;
    base_y_d    = base_y_q;
    down_d      = down_q;
    horiz_d     = horiz_q;
    total_d     = total_q;
    run_count_d = run_count_q;
    base_len_d  = base_len_q;
    leftover_d  = leftover_q;
    acc_d       = acc_q;
    run_idx_d   = run_idx_q;
    cur_len_d   = cur_len_q;
    pos_d       = pos_q;
    major_d     = major_q;
    busy_d      = busy_q;
    step_en     = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CMD_START) begin
            xa_d    = s_axis_tdata_i[C-1:0];
            ya_d    = s_axis_tdata_i[2*C-1:C];
            xb_d    = s_axis_tdata_i[3*C-1:2*C];
            yb_d    = s_axis_tdata_i[4*C-1:3*C];
            busy_d  = 1'b0;
            state_d = ST_DIFF;
          end else if (busy_q) begin
            step_en = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        // Raw deltas and the base endpoint; x order decided by the x delta sign
        ddx_d    = {xb_q[C-1], xb_q} - {xa_q[C-1], xa_q};
        ddy_d    = {yb_q[C-1], yb_q} - {ya_q[C-1], ya_q};
        swap_d   = ddx_d[N-1];
        base_x_d = swap_d ? xb_q : xa_q;
        base_y_d = swap_d ? yb_q : ya_q;
        state_d  = ST_ORDER;
      end
      ST_ORDER: begin
        down_d      = (ddy_q != '0) && (ddy_q[N-1] ^ swap_q);
        horiz_d     = dx_abs > dy_abs;
        total_d     = dmax + 1'b1;
        run_count_d = dmin + 1'b1;
        acc_d       = '0;
        run_idx_d   = '0;
        pos_d       = '0;
        major_d     = '0;
        div_start   = 1'b1;
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // Run zero never takes the extra pixel
        if (div_status.done) begin
          base_len_d = div_quo;
          leftover_d = div_rem;
          cur_len_d  = div_quo;
          state_d    = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          step_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (step_en) begin
      busy_d = !step_last;
      if (!step_last) begin
        major_d = major_inc[N-1:0];
        pos_d   = pos_inc[N-1:0];
        if (run_end) begin
          pos_d     = '0;
          run_idx_d = run_idx_q + 1'b1;
          acc_d     = acc_new;
          cur_len_d = cur_len_new;
        end
      end
    end
  end

  // Output register: load on a step, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    if (step_en) begin
      out_valid_d = 1'b1;
      px_d        = step_px;
      py_d        = step_py;
      last_d      = step_last;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      base_x_q    <= '0;
      base_y_q    <= '0;
      down_q      <= 1'b0;
      horiz_q     <= 1'b0;
      total_q     <= '0;
      run_count_q <= '0;
      base_len_q  <= '0;
      leftover_q  <= '0;
      acc_q       <= '0;
      run_idx_q   <= '0;
      cur_len_q   <= '0;
      pos_q       <= '0;
      major_q     <= '0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      base_x_q    <= base_x_d;
      base_y_q    <= base_y_d;
      down_q      <= down_d;
      horiz_q     <= horiz_d;
      total_q     <= total_d;
      run_count_q <= run_count_d;
      base_len_q  <= base_len_d;
      leftover_q  <= leftover_d;
      acc_q       <= acc_d;
      run_idx_q   <= run_idx_d;
      cur_len_q   <= cur_len_d;
      pos_q       <= pos_d;
      major_q     <= major_d;
    end
  end

  // Endpoint, delta and pixel payload registers
  always_ff @(posedge clk_i) begin
    xa_q   <= xa_d;
    ya_q   <= ya_d;
    xb_q   <= xb_d;
    yb_q   <= yb_d;
    ddx_q  <= ddx_d;
    ddy_q  <= ddy_d;
    swap_q <= swap_d;
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({py_q, px_q});
  assign m_axis_tlast_o  = last_q;

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == ST_DIVIDE))
    else $error("divider done outside divide state");

  // The final pixel ends the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && step_last) |=> (!busy_q && m_axis_tlast_o && m_axis_tvalid_o))
    else $error("line still active after last pixel");

  // Position inside the run stays below the run length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && state_q == ST_IDLE) |-> (pos_q < cur_len_q))
    else $error("run position beyond run length");

  // Wrap accumulator stays reduced modulo the run count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && state_q == ST_IDLE) |-> (acc_q < run_count_q))
    else $error("wrap accumulator out of range");

endmodule
